// File: design/evdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evdp_pkg: shared constants and types
// Sizes, register codes, sequencer states and inter-module structs of the
// extension field dot product unit.
// ----------------------------------------------------------------------------
package evdp_pkg;

  localparam int EXT_DEGREE     = 3;
  localparam int MAX_VECTOR_LEN = 256;

  localparam int COMP_W     = 2;
  localparam int POS_W      = 8;
  localparam int VAL_W      = 7;
  localparam int EXP_W      = 4;
  localparam int VLEN_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam int STORE_DEPTH = EXT_DEGREE * MAX_VECTOR_LEN;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ACC_DEPTH   = 2 * EXT_DEGREE - 1;
  localparam int ACC_IDX_W   = $clog2(ACC_DEPTH);
  localparam int KW          = $clog2(MAX_VECTOR_LEN);
  localparam int LEN_W       = $clog2(MAX_VECTOR_LEN + 1);
  localparam int PROD_W      = 2 * VAL_W;
  localparam int VAL_MAX     = 2 ** VAL_W - 1;
  localparam int ACC_W       = $clog2(EXT_DEGREE * MAX_VECTOR_LEN * VAL_MAX * VAL_MAX + 1);
  localparam int DIG_W       = $clog2(ACC_W);

  localparam logic [VAL_W-1:0]  RST_MODULUS    = VAL_W'(127);
  localparam logic [VAL_W-1:0]  RST_FOLD_CONST = VAL_W'(1);
  localparam logic [VAL_W-1:0]  RST_FOLD_MID   = VAL_W'(0);
  localparam logic [EXP_W-1:0]  RST_FOLD_EXP   = EXP_W'(1);
  localparam logic [VLEN_W-1:0] RST_VEC_LEN    = VLEN_W'(156);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS    = 3'd0,
    CFG_FOLD_CONST = 3'd1,
    CFG_FOLD_MID   = 3'd2,
    CFG_FOLD_EXP   = 3'd3,
    CFG_VEC_LEN    = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_LOAD,
    S_MAC,
    S_DRAIN,
    S_RED,
    S_FOLD,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    FP_TOP,
    FP_LO,
    FP_MID
  } fold_ph_e;

  typedef struct packed {
    logic [VAL_W-1:0]  modulus;
    logic [VAL_W-1:0]  fold_const;
    logic [VAL_W-1:0]  fold_mid;
    logic [EXP_W-1:0]  fold_exp;
    logic [VLEN_W-1:0] vec_len;
  } cfg_t;

  typedef struct packed {
    logic [COMP_W-1:0] component;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  a_value;
    logic [VAL_W-1:0]  b_value;
    logic              last_pair;
  } in_beat_t;

  typedef struct packed {
    logic [COMP_W-1:0] coeff_index;
    logic [VAL_W-1:0]  coeff_value;
    logic              last_coeff;
  } out_beat_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata_a;
    logic [VAL_W-1:0]  wdata_b;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } st_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] rdata_a;
    logic [VAL_W-1:0] rdata_b;
  } st_rsp_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [VAL_W-1:0] modulus;
  } mq_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] rem;
  } mq_rsp_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [COMP_W-1:0] comp,
                                                   input logic [KW-1:0] k);
    store_addr = ADDR_W'(comp) * ADDR_W'(MAX_VECTOR_LEN) + ADDR_W'(k);
  endfunction

endpackage
`default_nettype wire

// File: design/evdp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evdp_if: stream channels
// Valid/ready channels for loaded coefficient pairs and result coefficients.
// ----------------------------------------------------------------------------
interface evdp_in_if;
  logic                        valid;
  logic                        ready;
  logic [evdp_pkg::COMP_W-1:0] component;
  logic [evdp_pkg::POS_W-1:0]  position;
  logic [evdp_pkg::VAL_W-1:0]  a_value;
  logic [evdp_pkg::VAL_W-1:0]  b_value;
  logic                        last_pair;

  modport source (output valid, component, position, a_value, b_value, last_pair,
                  input ready);
  modport sink (input valid, component, position, a_value, b_value, last_pair,
                output ready);
endinterface

interface evdp_out_if;
  logic                        valid;
  logic                        ready;
  logic [evdp_pkg::COMP_W-1:0] coeff_index;
  logic [evdp_pkg::VAL_W-1:0]  coeff_value;
  logic                        last_coeff;

  modport source (output valid, coeff_index, coeff_value, last_coeff, input ready);
  modport sink (input valid, coeff_index, coeff_value, last_coeff, output ready);
endinterface
`default_nettype wire

// File: design/evdp_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evdp_store: coefficient stores
// Two synchronous RAMs for the A and B coefficients, one shared write
// address, independent read addresses, registered read data.
// ----------------------------------------------------------------------------
module evdp_store (
  input  wire                     clk_i,
  input  wire evdp_pkg::st_req_t  req_i,
  output evdp_pkg::st_rsp_t       rsp_o
);

  logic [evdp_pkg::VAL_W-1:0] a_store_q [evdp_pkg::STORE_DEPTH];
  logic [evdp_pkg::VAL_W-1:0] b_store_q [evdp_pkg::STORE_DEPTH];
  logic [evdp_pkg::VAL_W-1:0] rd_a_q;
  logic [evdp_pkg::VAL_W-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      a_store_q[req_i.waddr] <= req_i.wdata_a;
      b_store_q[req_i.waddr] <= req_i.wdata_b;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= a_store_q[req_i.raddr_a];
    rd_b_q <= b_store_q[req_i.raddr_b];
  end

  assign rsp_o.rdata_a = rd_a_q;
  assign rsp_o.rdata_b = rd_b_q;

endmodule
`default_nettype wire

// File: design/evdp_modq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evdp_modq: serial remainder unit
// Restoring reduction of an accumulator word modulo q, one dividend bit per
// cycle, MSB first; done pulses for one cycle with the remainder.
// ----------------------------------------------------------------------------
module evdp_modq (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire evdp_pkg::mq_req_t  req_i,
  output evdp_pkg::mq_rsp_t       rsp_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [evdp_pkg::DIG_W-1:0]     cnt_q;
  logic [evdp_pkg::ACC_W-1:0]     sh_q;
  logic [evdp_pkg::VAL_W-1:0]     rem_q;
  logic [evdp_pkg::VAL_W-1:0]     mod_q;
  logic [evdp_pkg::VAL_W:0]       trial;
  logic [evdp_pkg::VAL_W:0]       mod_ext;

  assign trial   = {rem_q, sh_q[evdp_pkg::ACC_W-1]};
  assign mod_ext = {1'b0, mod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == evdp_pkg::DIG_W'(evdp_pkg::ACC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= req_i.dividend;
      rem_q <= '0;
      mod_q <= req_i.modulus;
    end else if (busy_q) begin
      sh_q <= {sh_q[evdp_pkg::ACC_W-2:0], 1'b0};
      if (trial >= mod_ext) begin
        rem_q <= evdp_pkg::VAL_W'(trial - mod_ext);
      end else begin
        rem_q <= evdp_pkg::VAL_W'(trial);
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

// File: design/evdp_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evdp_core: load and compute sequencer
// Writes pairs into the stores, runs the pipelined MAC over all component
// pairs, reduces and folds the accumulators, and emits the coefficients.
// ----------------------------------------------------------------------------
module evdp_core (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire evdp_pkg::cfg_t      cfg_i,
  input  wire                      in_valid_i,
  input  wire evdp_pkg::in_beat_t  in_beat_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  output evdp_pkg::out_beat_t      out_beat_o,
  input  wire                      out_ready_i
);

  localparam int AIW = evdp_pkg::ACC_IDX_W;

  evdp_pkg::state_e   state_q, state_d;
  evdp_pkg::fold_ph_e ph_q, ph_d;

  logic [evdp_pkg::COMP_W-1:0] pi_q, pi_d, pj_q, pj_d;
  logic [evdp_pkg::KW-1:0]     k_q, k_d;
  logic [AIW-1:0]              ridx_q, ridx_d, fi_q, fi_d, eidx_q, eidx_d;
  logic                        wait_q, wait_d;
  logic [evdp_pkg::VAL_W-1:0]  top_q, top_d;

  logic                        s1_v_q, s2_v_q;
  logic [AIW-1:0]              s1_d_q, s2_d_q;
  logic [evdp_pkg::PROD_W-1:0] prod_q;

  logic [evdp_pkg::ACC_W-1:0]  acc_q [evdp_pkg::ACC_DEPTH];
  logic [AIW-1:0]              acc_ra, acc_wa;
  logic [evdp_pkg::ACC_W-1:0]  acc_rd, acc_wd;
  logic                        acc_we, acc_clr;

  logic                        out_v_q;
  evdp_pkg::out_beat_t         out_beat_q, out_beat_d;
  logic                        out_load, out_free;

  logic                        in_fire, issue;
  logic [evdp_pkg::LEN_W-1:0]  len, len_m1;
  logic [AIW-1:0]              lo_idx, mid_idx;
  logic                        use_mid;
  logic [evdp_pkg::VAL_W-1:0]  fold_k;
  logic [evdp_pkg::PROD_W-1:0] fold_prod;

  evdp_pkg::st_req_t st_req;
  evdp_pkg::st_rsp_t st_rsp;
  evdp_pkg::mq_req_t mq_req;
  evdp_pkg::mq_rsp_t mq_rsp;

  evdp_store u_store (
    .clk_i (clk_i),
    .req_i (st_req),
    .rsp_o (st_rsp)
  );

  evdp_modq u_modq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mq_req),
    .rsp_o  (mq_rsp)
  );

  assign len = (int'(cfg_i.vec_len) > evdp_pkg::MAX_VECTOR_LEN) ?
               evdp_pkg::LEN_W'(evdp_pkg::MAX_VECTOR_LEN) :
               evdp_pkg::LEN_W'(cfg_i.vec_len);
  assign len_m1 = len - 1'b1;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_v_q || out_ready_i;
  assign acc_rd   = acc_q[acc_ra];

  assign lo_idx    = fi_q - AIW'(evdp_pkg::EXT_DEGREE);
  assign mid_idx   = lo_idx + AIW'(cfg_i.fold_exp);
  assign use_mid   = int'(cfg_i.fold_exp) < evdp_pkg::EXT_DEGREE;
  assign fold_k    = (ph_q == evdp_pkg::FP_MID) ? cfg_i.fold_mid : cfg_i.fold_const;
  assign fold_prod = evdp_pkg::PROD_W'(fold_k) * evdp_pkg::PROD_W'(top_q);

  // store port: loads write, MAC issues reads
  always_comb begin
    st_req.we      = in_fire && (int'(in_beat_i.component) < evdp_pkg::EXT_DEGREE) &&
                     (int'(in_beat_i.position) < evdp_pkg::MAX_VECTOR_LEN);
    st_req.waddr   = evdp_pkg::store_addr(in_beat_i.component,
                                          evdp_pkg::KW'(in_beat_i.position));
    st_req.wdata_a = in_beat_i.a_value;
    st_req.wdata_b = in_beat_i.b_value;
    st_req.raddr_a = evdp_pkg::store_addr(pi_q, k_q);
    st_req.raddr_b = evdp_pkg::store_addr(pj_q, k_q);
  end

  always_comb begin
    state_d  = state_q;
    ph_d     = ph_q;
    pi_d     = pi_q;
    pj_d     = pj_q;
    k_d      = k_q;
    ridx_d   = ridx_q;
    fi_d     = fi_q;
    eidx_d   = eidx_q;
    wait_d   = wait_q;
    top_d    = top_q;
    issue    = 1'b0;
    in_ready_o = 1'b0;
    out_load = 1'b0;
    acc_clr  = 1'b0;
    acc_ra   = s2_d_q;
    acc_wa   = s2_d_q;
    acc_we   = s2_v_q;
    acc_wd   = acc_rd + evdp_pkg::ACC_W'(prod_q);
    mq_req.start    = 1'b0;
    mq_req.dividend = acc_rd;
    mq_req.modulus  = cfg_i.modulus;
    out_beat_d.coeff_index = evdp_pkg::COMP_W'(eidx_q);
    out_beat_d.coeff_value = acc_rd[evdp_pkg::VAL_W-1:0];
    out_beat_d.last_coeff  = (eidx_q == AIW'(evdp_pkg::EXT_DEGREE - 1));

    case (state_q)
      evdp_pkg::S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_fire && in_beat_i.last_pair) begin
          acc_clr = 1'b1;
          pi_d    = '0;
          pj_d    = '0;
          k_d     = '0;
          ridx_d  = '0;
          fi_d    = AIW'(evdp_pkg::ACC_DEPTH - 1);
          eidx_d  = '0;
          ph_d    = evdp_pkg::FP_TOP;
          wait_d  = 1'b0;
          if (cfg_i.modulus < evdp_pkg::VAL_W'(2)) begin
            state_d = evdp_pkg::S_EMIT;
          end else if (len == '0) begin
            state_d = evdp_pkg::S_RED;
          end else begin
            state_d = evdp_pkg::S_MAC;
          end
        end
      end

      evdp_pkg::S_MAC: begin
        issue = 1'b1;
        if (k_q == len_m1[evdp_pkg::KW-1:0]) begin
          k_d = '0;
          if (pj_q == evdp_pkg::COMP_W'(evdp_pkg::EXT_DEGREE - 1)) begin
            pj_d = '0;
            if (pi_q == evdp_pkg::COMP_W'(evdp_pkg::EXT_DEGREE - 1)) begin
              state_d = evdp_pkg::S_DRAIN;
            end else begin
              pi_d = pi_q + 1'b1;
            end
          end else begin
            pj_d = pj_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      evdp_pkg::S_DRAIN: begin
        if (!s1_v_q && !s2_v_q) begin
          state_d = evdp_pkg::S_RED;
        end
      end

      evdp_pkg::S_RED: begin
        acc_ra = ridx_q;
        acc_wa = ridx_q;
        acc_wd = evdp_pkg::ACC_W'(mq_rsp.rem);
        if (!wait_q) begin
          mq_req.start = 1'b1;
          wait_d       = 1'b1;
        end else if (mq_rsp.done) begin
          acc_we = 1'b1;
          wait_d = 1'b0;
          if (ridx_q == AIW'(evdp_pkg::ACC_DEPTH - 1)) begin
            state_d = evdp_pkg::S_FOLD;
            ph_d    = evdp_pkg::FP_TOP;
          end else begin
            ridx_d = ridx_q + 1'b1;
          end
        end
      end

      evdp_pkg::S_FOLD: begin
        acc_wd          = evdp_pkg::ACC_W'(mq_rsp.rem);
        mq_req.dividend = acc_rd + evdp_pkg::ACC_W'(fold_prod);
        case (ph_q)
          evdp_pkg::FP_TOP: begin
            acc_ra = fi_q;
            top_d  = acc_rd[evdp_pkg::VAL_W-1:0];
            ph_d   = evdp_pkg::FP_LO;
          end
          evdp_pkg::FP_LO, evdp_pkg::FP_MID: begin
            acc_ra = (ph_q == evdp_pkg::FP_MID) ? mid_idx : lo_idx;
            acc_wa = acc_ra;
            if (!wait_q) begin
              mq_req.start = 1'b1;
              wait_d       = 1'b1;
            end else if (mq_rsp.done) begin
              acc_we = 1'b1;
              wait_d = 1'b0;
              if (ph_q == evdp_pkg::FP_LO && use_mid) begin
                ph_d = evdp_pkg::FP_MID;
              end else if (fi_q == AIW'(evdp_pkg::EXT_DEGREE)) begin
                state_d = evdp_pkg::S_EMIT;
              end else begin
                fi_d = fi_q - 1'b1;
                ph_d = evdp_pkg::FP_TOP;
              end
            end
          end
          default: begin
            ph_d = evdp_pkg::FP_TOP;
          end
        endcase
      end

      evdp_pkg::S_EMIT: begin
        acc_ra = eidx_q;
        if (out_free) begin
          out_load = 1'b1;
          if (eidx_q == AIW'(evdp_pkg::EXT_DEGREE - 1)) begin
            state_d = evdp_pkg::S_LOAD;
          end else begin
            eidx_d = eidx_q + 1'b1;
          end
        end
      end

      default: begin
        state_d = evdp_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= evdp_pkg::S_LOAD;
      ph_q    <= evdp_pkg::FP_TOP;
      pi_q    <= '0;
      pj_q    <= '0;
      k_q     <= '0;
      ridx_q  <= '0;
      fi_q    <= '0;
      eidx_q  <= '0;
      wait_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      pi_q    <= pi_d;
      pj_q    <= pj_d;
      k_q     <= k_d;
      ridx_q  <= ridx_d;
      fi_q    <= fi_d;
      eidx_q  <= eidx_d;
      wait_q  <= wait_d;
      s1_v_q  <= issue;
      s2_v_q  <= s1_v_q;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // MAC pipeline: read data, product, accumulate
  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    s1_d_q <= AIW'(pi_q) + AIW'(pj_q);
    s2_d_q <= s1_d_q;
    prod_q <= evdp_pkg::PROD_W'(st_rsp.rdata_a) * evdp_pkg::PROD_W'(st_rsp.rdata_b);
    if (out_load) begin
      out_beat_q <= out_beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_clr) begin
      for (int i = 0; i < evdp_pkg::ACC_DEPTH; i++) begin
        acc_q[i] <= '0;
      end
    end else if (acc_we) begin
      acc_q[acc_wa] <= acc_wd;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_beat_o  = out_beat_q;

endmodule
`default_nettype wire

// File: design/ext_field_vector_dot_product_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ext_field_vector_dot_product_unit: extension field inner product
// Loads coefficient pairs of two vectors over F_q^3 and emits the reduced
// product coefficients after the pair marked last.
//
// in_i takes one pair per beat, one beat per cycle, written into the A and B
// RAMs. The beat with last_pair set starts the computation and ready drops
// until all three result beats are in the output register. The MAC reads
// both RAMs once per cycle, len positions for each of the nine component
// pairs, len being the vector length capped at 256. Five reductions follow,
// then two fold steps (one remainder pass fewer each when the middle term is
// dropped) through the same serial remainder unit. out_o carries indexes
// 0..2, last_coeff on the final one; a stalled receiver holds the output
// register and the core waits.
// The next load beat is taken as soon as the final result is registered.
// Reset restores the register defaults and leaves the RAMs undefined; no
// clearing pass is needed. Configuration writes take effect on the next edge.
// ----------------------------------------------------------------------------
module ext_field_vector_dot_product_unit (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [evdp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [evdp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  evdp_in_if.sink                             in_i,
  evdp_out_if.source                          out_o
);

  evdp_pkg::cfg_t      cfg_q;
  evdp_pkg::in_beat_t  in_beat;
  evdp_pkg::out_beat_t out_beat;
  logic                in_ready;
  logic                out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulus    <= evdp_pkg::RST_MODULUS;
      cfg_q.fold_const <= evdp_pkg::RST_FOLD_CONST;
      cfg_q.fold_mid   <= evdp_pkg::RST_FOLD_MID;
      cfg_q.fold_exp   <= evdp_pkg::RST_FOLD_EXP;
      cfg_q.vec_len    <= evdp_pkg::RST_VEC_LEN;
    end else if (cfg_we_i) begin
      case (evdp_pkg::cfg_reg_e'(cfg_index_i))
        evdp_pkg::CFG_MODULUS: begin
          cfg_q.modulus <= cfg_wdata_i[evdp_pkg::VAL_W-1:0];
        end
        evdp_pkg::CFG_FOLD_CONST: begin
          cfg_q.fold_const <= cfg_wdata_i[evdp_pkg::VAL_W-1:0];
        end
        evdp_pkg::CFG_FOLD_MID: begin
          cfg_q.fold_mid <= cfg_wdata_i[evdp_pkg::VAL_W-1:0];
        end
        evdp_pkg::CFG_FOLD_EXP: begin
          cfg_q.fold_exp <= cfg_wdata_i[evdp_pkg::EXP_W-1:0];
        end
        evdp_pkg::CFG_VEC_LEN: begin
          cfg_q.vec_len <= cfg_wdata_i[evdp_pkg::VLEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_beat.component = in_i.component;
  assign in_beat.position  = in_i.position;
  assign in_beat.a_value   = in_i.a_value;
  assign in_beat.b_value   = in_i.b_value;
  assign in_beat.last_pair = in_i.last_pair;
  assign in_i.ready        = in_ready;

  evdp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_beat_i   (in_beat),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_beat_o  (out_beat),
    .out_ready_i (out_o.ready)
  );

  assign out_o.valid       = out_valid;
  assign out_o.coeff_index = out_beat.coeff_index;
  assign out_o.coeff_value = out_beat.coeff_value;
  assign out_o.last_coeff  = out_beat.last_coeff;

endmodule
`default_nettype wire

// File: test/ext_field_vector_dot_product_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ext_field_vector_dot_product_unit_tb: extension field inner product testbench
// Loads coefficient pairs of two vectors over F_q^3, predicts the folded and
// reduced product coefficients for every pair marked last and checks each
// result beat in order. It covers directed corners of the fold and reduction
// settings, short random vectors with and without random sender gaps and
// receiver stalls, and a longer vector loaded back to back.
// ----------------------------------------------------------------------------
module ext_field_vector_dot_product_unit_tb;
  import evdp_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  evdp_in_if  in_ch ();
  evdp_out_if out_ch ();

  ext_field_vector_dot_product_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  cfg_t             cur_cfg;
  logic [VAL_W-1:0] a_mem [STORE_DEPTH];
  logic [VAL_W-1:0] b_mem [STORE_DEPTH];
  bit               written [STORE_DEPTH];
  out_beat_t        pending_coeffs [$];

  int err_count      = 0;
  int n_runs         = 0;
  int n_beats        = 0;
  int src_gap_pct    = 0;
  int sink_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Dot products of all component pairs, reduce, fold x^4 then x^3, reduce.
  function automatic void compute_product_coeffs();
    longint unsigned acc [ACC_DEPTH];
    longint unsigned q;
    longint unsigned top;
    int              len;
    int              lo;
    int              mid;
    out_beat_t       beat;
    len = (cur_cfg.vec_len > MAX_VECTOR_LEN) ? MAX_VECTOR_LEN : int'(cur_cfg.vec_len);
    q = 64'(cur_cfg.modulus);
    foreach (acc[i]) acc[i] = 0;
    if (q >= 2) begin
      for (int i = 0; i < EXT_DEGREE; i++)
        for (int j = 0; j < EXT_DEGREE; j++)
          for (int k = 0; k < len; k++)
            acc[i+j] += 64'(a_mem[i*MAX_VECTOR_LEN+k]) * 64'(b_mem[j*MAX_VECTOR_LEN+k]);
      foreach (acc[i]) acc[i] = acc[i] % q;
      for (int i = ACC_DEPTH - 1; i >= EXT_DEGREE; i--) begin
        top = acc[i];
        lo = i - EXT_DEGREE;
        acc[lo] = (acc[lo] + 64'(cur_cfg.fold_const) * top) % q;
        if (cur_cfg.fold_exp < EXT_DEGREE) begin
          mid = lo + int'(cur_cfg.fold_exp);
          acc[mid] = (acc[mid] + 64'(cur_cfg.fold_mid) * top) % q;
        end
      end
    end
    for (int i = 0; i < EXT_DEGREE; i++) begin
      beat.coeff_index = COMP_W'(i);
      beat.coeff_value = VAL_W'(acc[i]);
      beat.last_coeff  = (i == EXT_DEGREE - 1);
      pending_coeffs.push_back(beat);
    end
  endfunction

  function automatic bit all_written(input int len);
    int n;
    n = (len > MAX_VECTOR_LEN) ? MAX_VECTOR_LEN : len;
    for (int c = 0; c < EXT_DEGREE; c++)
      for (int k = 0; k < n; k++)
        if (!written[c*MAX_VECTOR_LEN+k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    int   r;
    r = $urandom_range(11);
    c.modulus    = (r == 0) ? VAL_W'($urandom_range(1)) : VAL_W'($urandom_range(127, 2));
    c.fold_const = VAL_W'($urandom_range(127));
    c.fold_mid   = VAL_W'($urandom_range(127));
    c.fold_exp   = ($urandom_range(3) == 0) ? EXP_W'($urandom_range(15, 3))
                                            : EXP_W'($urandom_range(2));
    r = $urandom_range(15);
    c.vec_len    = (r == 0) ? '0 : (r < 12) ? VLEN_W'($urandom_range(6, 1))
                                            : VLEN_W'($urandom_range(20, 7));
    return c;
  endfunction

  task automatic send_pair(input logic [COMP_W-1:0] comp, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                           input logic last);
    int addr;
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.component <= comp;
    in_ch.position  <= pos;
    in_ch.a_value   <= a;
    in_ch.b_value   <= b;
    in_ch.last_pair <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (comp < EXT_DEGREE) begin
      addr = int'(comp) * MAX_VECTOR_LEN + int'(pos);
      a_mem[addr]   = a;
      b_mem[addr]   = b;
      written[addr] = 1'b1;
    end
    if (last) begin
      compute_product_coeffs();
      n_runs++;
    end
  endtask

  // Drops valid and holds off until every expected beat has drained.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_coeffs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    wait_idle();
    write_reg(CFG_MODULUS, CFG_DATA_W'(c.modulus));
    write_reg(CFG_FOLD_CONST, CFG_DATA_W'(c.fold_const));
    write_reg(CFG_FOLD_MID, CFG_DATA_W'(c.fold_mid));
    write_reg(CFG_FOLD_EXP, CFG_DATA_W'(c.fold_exp));
    write_reg(CFG_VEC_LEN, CFG_DATA_W'(c.vec_len));
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic test_directed_corners();
    apply_cfg('{7'd127, 7'd1, 7'd0, 4'd1, 9'd2});
    send_pair(2'd0, 8'd0, 7'd127, 7'd127, 1'b0);
    send_pair(2'd0, 8'd1, 7'd0, 7'd0, 1'b0);
    send_pair(2'd1, 8'd0, 7'd127, 7'd0, 1'b0);
    send_pair(2'd1, 8'd1, 7'd0, 7'd127, 1'b0);
    send_pair(2'd2, 8'd0, 7'd127, 7'd127, 1'b0);
    send_pair(2'd2, 8'd1, 7'd85, 7'd42, 1'b1);
    // out-of-range component: write dropped, still starts
    send_pair(2'd3, 8'd255, 7'd127, 7'd127, 1'b1);
    send_pair(2'd2, 8'd255, 7'd127, 7'd127, 1'b1);
    apply_cfg('{7'd127, 7'd126, 7'd126, 4'd0, 9'd2});
    send_pair(2'd0, 8'd0, 7'd127, 7'd127, 1'b1);
    apply_cfg('{7'd127, 7'd126, 7'd126, 4'd2, 9'd2});
    send_pair(2'd1, 8'd1, 7'd42, 7'd85, 1'b1);
    // middle term dropped
    apply_cfg('{7'd127, 7'd5, 7'd9, 4'd3, 9'd2});
    send_pair(2'd2, 8'd0, 7'd100, 7'd3, 1'b1);
    apply_cfg('{7'd127, 7'd5, 7'd9, 4'd15, 9'd2});
    send_pair(2'd0, 8'd1, 7'd1, 7'd126, 1'b1);
    // degenerate moduli
    apply_cfg('{7'd1, 7'd5, 7'd9, 4'd1, 9'd2});
    send_pair(2'd1, 8'd0, 7'd77, 7'd99, 1'b1);
    apply_cfg('{7'd0, 7'd5, 7'd9, 4'd1, 9'd2});
    send_pair(2'd2, 8'd1, 7'd64, 7'd63, 1'b1);
    // residues and fold constants above q, then lengths 0 and 1
    apply_cfg('{7'd2, 7'd127, 7'd127, 4'd1, 9'd2});
    send_pair(2'd0, 8'd0, 7'd127, 7'd127, 1'b1);
    apply_cfg('{7'd127, 7'd1, 7'd0, 4'd1, 9'd0});
    send_pair(2'd1, 8'd1, 7'd11, 7'd22, 1'b1);
    apply_cfg('{7'd3, 7'd0, 7'd127, 4'd1, 9'd1});
    send_pair(2'd1, 8'd0, 7'd127, 7'd1, 1'b1);
  endtask

  // Mostly complete vector loads in shuffled order, with ignored-component
  // noise, plus short partial reloads over already written entries.
  task automatic test_random_vectors(input int n_items);
    int   sent;
    int   len;
    int   n;
    int   j;
    int   tmp;
    int   order [$];
    cfg_t c;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) begin
        c = random_cfg();
        apply_cfg(c);
      end
      len = (cur_cfg.vec_len > MAX_VECTOR_LEN) ? MAX_VECTOR_LEN : int'(cur_cfg.vec_len);
      if ($urandom_range(9) < 7 || !all_written(len)) begin
        order.delete();
        for (int cc = 0; cc < EXT_DEGREE; cc++)
          for (int k = 0; k < len; k++) order.push_back(cc * MAX_VECTOR_LEN + k);
        if (order.size() == 0) order.push_back($urandom_range(STORE_DEPTH - 1));
        for (int i = order.size() - 1; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        foreach (order[i]) begin
          if ($urandom_range(9) == 0)
            send_pair(2'd3, POS_W'($urandom_range(255)), VAL_W'($urandom_range(127)),
                      VAL_W'($urandom_range(127)), 1'b0);
          send_pair(COMP_W'(order[i] / MAX_VECTOR_LEN), POS_W'(order[i] % MAX_VECTOR_LEN),
                    VAL_W'($urandom_range(127)), VAL_W'($urandom_range(127)),
                    i == order.size() - 1);
          sent++;
        end
      end else begin
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++) begin
          send_pair(COMP_W'($urandom_range(3)), POS_W'($urandom_range(255)),
                    VAL_W'($urandom_range(127)), VAL_W'($urandom_range(127)), i == n - 1);
          sent++;
        end
      end
    end
  endtask

  // Longer vector loaded interleaved across components, then reused.
  task automatic test_long_vector();
    cfg_t c;
    int   n;
    c = random_cfg();
    c.modulus = 7'd127;
    c.vec_len = 9'd24;
    apply_cfg(c);
    n = EXT_DEGREE * int'(c.vec_len);
    for (int i = 0; i < n; i++)
      send_pair(COMP_W'(i % EXT_DEGREE), POS_W'(i / EXT_DEGREE),
                VAL_W'($urandom_range(127)), VAL_W'($urandom_range(127)),
                i == n - 1);
    c = random_cfg();
    c.vec_len = 9'd24;
    apply_cfg(c);
    send_pair(COMP_W'($urandom_range(2)), POS_W'($urandom_range(23)),
              VAL_W'($urandom_range(127)), VAL_W'($urandom_range(127)), 1'b1);
  endtask

  // Result beat checker and receiver stall generator.
  initial begin
    out_beat_t want;
    out_beat_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        n_beats++;
        got = '{out_ch.coeff_index, out_ch.coeff_value, out_ch.last_coeff};
        if (pending_coeffs.size() == 0) begin
          report_mismatch($sformatf("unexpected beat idx %0d val %0d last %0b",
                                    got.coeff_index, got.coeff_value, got.last_coeff));
        end else begin
          want = pending_coeffs.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              "beat %0d: got idx %0d val %0d last %0b, want idx %0d val %0d last %0b",
              n_beats, got.coeff_index, got.coeff_value, got.last_coeff,
              want.coeff_index, want.coeff_value, want.last_coeff));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_MODULUS;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.component <= '0;
    in_ch.position  <= '0;
    in_ch.a_value   <= '0;
    in_ch.b_value   <= '0;
    in_ch.last_pair <= 1'b0;
    cur_cfg = '{RST_MODULUS, RST_FOLD_CONST, RST_FOLD_MID, RST_FOLD_EXP, RST_VEC_LEN};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_gap_pct    = 6;
    sink_stall_pct = 46;
    test_directed_corners();
    test_random_vectors(65);
    src_gap_pct    = 46;
    sink_stall_pct = 6;
    test_random_vectors(65);
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    test_random_vectors(65);
    test_long_vector();

    wait_idle();
    repeat (300) @(posedge clk);
    $display("Ran %0d dot products, checked %0d result beats", n_runs, n_beats);
    $display("Covered lengths 0 to 24, moduli 0 to 127, all fold exponents, idle mixes");
    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
